>>> rtl/hci_pkg.sv
package hci_pkg;

    // Width of the SysV hash as it leaves the block, and the counter that walks its bits.
    localparam int HASH_BITS  = 28;
    localparam int HASH_CNT_W = 5;

    // Register map of the configuration port.
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_BUCKET_COUNT = 3'd0;
    localparam logic [7:0] BUCKET_COUNT_RESET = 8'd100;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STATUS_WALK_OVER = 2'd2;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       has_byte;
        logic       is_last;
        logic [7:0] symbol_index;
    } hci_in_t;

    typedef struct packed {
        logic [27:0] hash_value;
        logic [6:0]  bucket_index;
        logic        collided;
        logic [8:0]  walk_length;
        logic [8:0]  entry_count;
        logic [1:0]  status;
    } hci_out_t;

    typedef enum logic [3:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_MOD,
        STEP_HEAD_RD,
        STEP_REJECT,
        STEP_HEAD_CHK,
        STEP_HEAD_WR,
        STEP_WALK,
        STEP_WALK_END,
        STEP_LINK_WR,
        STEP_OVER,
        STEP_FINISH
    } step_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_CLR_DONE,
        COND_ITEM_LAST,
        COND_DIV_DONE,
        COND_BAD_SYM,
        COND_HEAD_EMPTY,
        COND_WALK_STOP,
        COND_LINK_END,
        COND_OUT_FREE
    } cond_t;

    // Datapath controls carried by one microcode word.
    typedef struct packed {
        logic accept;
        logic clear;
        logic div;
        logic bkt_rd;
        logic head_latch;
        logic follow;
        logic bkt_wr;
        logic chain_wr;
        logic set_bad;
        logic set_over;
        logic finish;
    } ctrl_t;

    // Condition inputs that the sequencer may branch on.
    typedef struct packed {
        logic clr_done;
        logic item_last;
        logic div_done;
        logic bad_sym;
        logic head_empty;
        logic walk_stop;
        logic link_end;
        logic out_free;
    } flags_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    localparam ctrl_t CTRL_NONE = '0;

    // The control store: when the condition holds the program goes to jump, else to next.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w.ctrl = CTRL_NONE;
        w.cond = COND_ALWAYS;
        w.jump = STEP_IDLE;
        w.next = STEP_IDLE;
        case (step)
            STEP_CLEAR:
            begin
                w.ctrl.clear = 1'b1;
                w.cond = COND_CLR_DONE;
                w.jump = STEP_IDLE;
                w.next = STEP_CLEAR;
            end
            STEP_IDLE:
            begin
                w.ctrl.accept = 1'b1;
                w.cond = COND_ITEM_LAST;
                w.jump = STEP_MOD;
                w.next = STEP_IDLE;
            end
            STEP_MOD:
            begin
                w.ctrl.div = 1'b1;
                w.cond = COND_DIV_DONE;
                w.jump = STEP_HEAD_RD;
                w.next = STEP_MOD;
            end
            STEP_HEAD_RD:
            begin
                w.ctrl.bkt_rd = 1'b1;
                w.cond = COND_BAD_SYM;
                w.jump = STEP_REJECT;
                w.next = STEP_HEAD_CHK;
            end
            STEP_REJECT:
            begin
                w.ctrl.set_bad = 1'b1;
                w.jump = STEP_FINISH;
            end
            STEP_HEAD_CHK:
            begin
                w.ctrl.head_latch = 1'b1;
                w.cond = COND_HEAD_EMPTY;
                w.jump = STEP_HEAD_WR;
                w.next = STEP_WALK;
            end
            STEP_HEAD_WR:
            begin
                w.ctrl.bkt_wr = 1'b1;
                w.jump = STEP_FINISH;
            end
            STEP_WALK:
            begin
                w.ctrl.follow = 1'b1;
                w.cond = COND_WALK_STOP;
                w.jump = STEP_WALK_END;
                w.next = STEP_WALK;
            end
            STEP_WALK_END:
            begin
                w.cond = COND_LINK_END;
                w.jump = STEP_LINK_WR;
                w.next = STEP_OVER;
            end
            STEP_LINK_WR:
            begin
                w.ctrl.chain_wr = 1'b1;
                w.jump = STEP_FINISH;
            end
            STEP_OVER:
            begin
                w.ctrl.set_over = 1'b1;
                w.jump = STEP_FINISH;
            end
            STEP_FINISH:
            begin
                w.ctrl.finish = 1'b1;
                w.cond = COND_OUT_FREE;
                w.jump = STEP_IDLE;
                w.next = STEP_FINISH;
            end
            default:
            begin
                w.jump = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // One SysV hash step on a 32-bit accumulator.
    function automatic logic [31:0] hci_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = {h[27:0], 4'b0000} + {24'b0, b};
        t = t ^ {24'b0, t[31:28], 4'b0000};
        return t;
    endfunction

endpackage

>>> rtl/hci_sequencer.sv
module hci_sequencer
    import hci_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   taken;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_CLR_DONE:   taken = flags.clr_done;
            COND_ITEM_LAST:  taken = flags.item_last;
            COND_DIV_DONE:   taken = flags.div_done;
            COND_BAD_SYM:    taken = flags.bad_sym;
            COND_HEAD_EMPTY: taken = flags.head_empty;
            COND_WALK_STOP:  taken = flags.walk_stop;
            COND_LINK_END:   taken = flags.link_end;
            COND_OUT_FREE:   taken = flags.out_free;
            default:         taken = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next = taken ? word.jump : word.next;
    end

    always_comb
    begin
        ctrl = word.ctrl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/sysv_hash_chain_insert_top.sv
// SysV symbol hash table builder. Name bytes arrive at most one per item on the byte channel
// and are hashed at one item per cycle while the builder is idle; byte_ready is low during
// an insert. An item with is_last set takes the insert path: a bit-serial modulo by the
// bucket count, a bucket read, then a rejection of a bad symbol index, a bucket write, or a
// chain walk of one link per cycle and a link write (or an over-bound status). The microcode
// sequencer orders these steps, and each table has a single read port. A finished result
// waits in an output register while new name bytes keep flowing. After reset a clearing
// pass zeroes both tables before the first item is taken; configuration writes are taken
// throughout.
module sysv_hash_chain_insert_top
    import hci_pkg::*;
#(
    parameter int MAX_BUCKETS   = 128,
    parameter int CHAIN_ENTRIES = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  hci_in_t               byte_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output hci_out_t              result_item
);

    localparam int BW      = $clog2(MAX_BUCKETS);
    localparam int CW      = $clog2(CHAIN_ENTRIES);
    localparam int WW      = $clog2(CHAIN_ENTRIES + 1);
    localparam int CLR_LEN = (MAX_BUCKETS > CHAIN_ENTRIES) ? MAX_BUCKETS : CHAIN_ENTRIES;
    localparam int CLRW    = $clog2(CLR_LEN);

    ctrl_t  ctrl;
    flags_t flags;

    // Configuration register.
    logic [7:0] bucket_count_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_BUCKET_COUNT[2]);
    assign prdata = (paddr[2] == ADDR_BUCKET_COUNT[2]) ? {24'b0, bucket_count_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            bucket_count_reg <= pwdata[7:0];
        end
    end

    // Effective divisor: zero acts as one, large values are capped at the table size.
    logic [7:0] nb;
    always_comb
    begin
        if (bucket_count_reg == 8'd0)
        begin
            nb = 8'd1;
        end
        else if (32'(bucket_count_reg) > MAX_BUCKETS)
        begin
            nb = 8'(MAX_BUCKETS);
        end
        else
        begin
            nb = bucket_count_reg;
        end
    end

    // Datapath registers.
    logic [31:0]           acc_reg;
    logic [31:0]           fold_next;
    logic [HASH_BITS-1:0]  hash_reg;
    logic [7:0]            sym_reg;
    logic                  bad_reg;
    logic [HASH_CNT_W-1:0] div_cnt_reg;
    logic [7:0]            rem_reg;
    logic [8:0]            rem_shift;
    logic [8:0]            rem_next;
    logic                  div_bit;
    logic [7:0]            bkt_rd_reg;
    logic [7:0]            chain_rd_reg;
    logic [CW-1:0]         p_reg;
    logic [WW-1:0]         walk_reg;
    logic                  collided_reg;
    logic [1:0]            status_reg;
    logic [WW-1:0]         count_reg;
    logic [WW-1:0]         count_next;
    logic [CLRW-1:0]       clr_cnt_reg;
    logic                  result_valid_reg;
    hci_out_t              result_item_reg;
    logic                  accepted;
    logic                  item_bad;
    logic                  walk_over;
    logic                  finish_fire;
    logic                  follow_fire;

    logic [7:0] bucket_mem [MAX_BUCKETS];
    logic [7:0] chain_mem  [CHAIN_ENTRIES];

    assign byte_ready = ctrl.accept;
    assign accepted   = byte_valid && byte_ready;
    assign fold_next  = byte_item.has_byte ? hci_fold(acc_reg, byte_item.name_byte) : acc_reg;
    assign item_bad   = (byte_item.symbol_index == 8'd0) ||
                        (32'(byte_item.symbol_index) >= CHAIN_ENTRIES);

    assign div_bit   = hash_reg[HASH_CNT_W'(HASH_BITS - 1) - div_cnt_reg];
    assign rem_shift = {rem_reg, div_bit};
    assign rem_next  = (rem_shift >= {1'b0, nb}) ? (rem_shift - {1'b0, nb}) : rem_shift;

    assign walk_over   = (walk_reg == WW'(CHAIN_ENTRIES));
    assign follow_fire = ctrl.follow && !flags.walk_stop;
    assign finish_fire = ctrl.finish && flags.out_free;

    assign flags.clr_done   = (clr_cnt_reg == CLRW'(CLR_LEN - 1));
    assign flags.item_last  = accepted && byte_item.is_last;
    assign flags.div_done   = (div_cnt_reg == HASH_CNT_W'(HASH_BITS - 1));
    assign flags.bad_sym    = bad_reg;
    assign flags.head_empty = (bkt_rd_reg == 8'd0);
    assign flags.walk_stop  = (chain_rd_reg == 8'd0) || walk_over;
    assign flags.link_end   = (chain_rd_reg == 8'd0);
    assign flags.out_free   = !result_valid_reg || result_ready;

    hci_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctrl.clear && !flags.clr_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Hash accumulator returns to zero after each name.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (accepted)
        begin
            acc_reg <= byte_item.is_last ? 32'b0 : fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flags.item_last)
        begin
            hash_reg     <= fold_next[HASH_BITS-1:0];
            sym_reg      <= byte_item.symbol_index;
            bad_reg      <= item_bad;
            div_cnt_reg  <= '0;
            rem_reg      <= 8'd0;
            walk_reg     <= '0;
            collided_reg <= 1'b0;
            status_reg   <= STATUS_OK;
        end
        else
        begin
            if (ctrl.div)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                rem_reg     <= rem_next[7:0];
            end
            if (ctrl.head_latch)
            begin
                collided_reg <= (bkt_rd_reg != 8'd0);
                p_reg        <= CW'(bkt_rd_reg);
            end
            if (follow_fire)
            begin
                p_reg    <= CW'(chain_rd_reg);
                walk_reg <= walk_reg + 1'b1;
            end
            if (ctrl.set_bad)
            begin
                status_reg <= STATUS_BAD_INDEX;
            end
            if (ctrl.set_over)
            begin
                status_reg <= STATUS_WALK_OVER;
            end
        end
    end

    // Bucket head table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear && (32'(clr_cnt_reg) < MAX_BUCKETS))
        begin
            bucket_mem[clr_cnt_reg[BW-1:0]] <= 8'd0;
        end
        else if (ctrl.bkt_wr)
        begin
            bucket_mem[BW'(rem_reg)] <= sym_reg;
        end
        if (ctrl.bkt_rd)
        begin
            bkt_rd_reg <= bucket_mem[BW'(rem_reg)];
        end
    end

    // Chain link table: the read address follows the data just read.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear && (32'(clr_cnt_reg) < CHAIN_ENTRIES))
        begin
            chain_mem[clr_cnt_reg[CW-1:0]] <= 8'd0;
        end
        else if (ctrl.chain_wr)
        begin
            chain_mem[p_reg] <= sym_reg;
        end
        if (ctrl.head_latch)
        begin
            chain_rd_reg <= chain_mem[CW'(bkt_rd_reg)];
        end
        else if (follow_fire)
        begin
            chain_rd_reg <= chain_mem[CW'(chain_rd_reg)];
        end
    end

    // Insert counter, saturating at the chain table size.
    always_comb
    begin
        count_next = count_reg;
        if ((status_reg == STATUS_OK) && (count_reg != WW'(CHAIN_ENTRIES)))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (finish_fire)
        begin
            count_reg <= count_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (finish_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            result_item_reg.hash_value   <= hash_reg;
            result_item_reg.bucket_index <= rem_reg[6:0];
            result_item_reg.collided     <= collided_reg;
            result_item_reg.walk_length  <= 9'(walk_reg);
            result_item_reg.entry_count  <= 9'(count_next);
            result_item_reg.status       <= status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

>>> rtl/hci_checker.sv
module hci_checker
    import hci_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     result_valid,
    input logic     result_ready,
    input hci_out_t result_item
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.status == STATUS_OK) ||
                         (result_item.status == STATUS_BAD_INDEX) ||
                         (result_item.status == STATUS_WALK_OVER))
        else $error("result status code out of range");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_item.status == STATUS_BAD_INDEX)
        |-> !result_item.collided && (result_item.walk_length == 9'd0))
        else $error("rejected insert reports a walk");

    a_over_collided: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_item.status == STATUS_WALK_OVER) |-> result_item.collided)
        else $error("walk bound hit without a collision");

    a_walk_needs_collision: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.collided |-> (result_item.walk_length == 9'd0))
        else $error("chain links followed on an empty bucket");

endmodule

bind sysv_hash_chain_insert_top hci_checker u_hci_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);
